/* rtl/sis_pkg.sv */
package sis_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 16;
    localparam int RATE_BITS  = 16;
    localparam int DRAW_BITS  = 16;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SLOT_W    = $clog2(MAX_DEGREE);
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int NBR_DEPTH = MAX_NODES * MAX_DEGREE;
    localparam int PD_W      = DRAW_BITS + DEG_W;
    localparam int PR_W      = RATE_BITS + DEG_W;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_SET_NODE = 2'd1,
        CMD_EVAL     = 2'd2
    } cmd_code_t;

    typedef struct packed {
        logic item_ld;
        logic set_wr;
        logic look;
        logic deg_ld;
        logic add_wr;
        logic scan_step;
        logic mul_ld;
        logic cmp_ld;
        logic res_ld;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       self_inf;
        logic       deg_zero;
        logic       scan_last;
        logic       slot_free;
    } stat_t;

endpackage

/* rtl/sis_contact_process_step_core.sv */
// SIS contact process step on a stored graph of up to 64 nodes.
// Input channel (in_valid/in_ready): one beat per command. Add edge appends
// a neighbor to a node's list, set node loads its rates and start state,
// evaluate draws the node's next state; code 3 is dropped.
// Output channel (out_valid/out_ready): one beat per add edge and evaluate,
// none for set node.
// Items are handled one at a time; in_ready is high while the controller
// is idle. Evaluate steps through the node's neighbors (up to 16), since
// the neighbor list RAM returns one entry per cycle. An infected node or a
// node with no neighbors skips the scan.
// The last evaluate of a sweep commits all new states in the same pass.
// A finished result sits in the output register, so the next item is taken
// while it waits; a following result waits until out_ready takes the beat.
// Reset clears degrees, node states and the output valid; neighbor lists
// and rates hold nothing defined until written. No clearing pass is needed.
module sis_contact_process_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [sis_pkg::NODE_W-1:0]    node,
    input  logic [sis_pkg::NODE_W-1:0]    neighbor,
    input  logic [sis_pkg::RATE_BITS-1:0] infect_rate,
    input  logic [sis_pkg::RATE_BITS-1:0] recover_rate,
    input  logic                          start_infected,
    input  logic [sis_pkg::DRAW_BITS-1:0] random_draw,
    input  logic                          last_node,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sis_pkg::NODE_W-1:0]    node_out,
    output logic                          next_infected,
    output logic                          sweep_done,
    output logic                          any_infected,
    output logic                          list_full
);

    sis_pkg::ctrl_t ctrl;
    sis_pkg::stat_t stat;

    sis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    sis_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cmd            (cmd),
        .node           (node),
        .neighbor       (neighbor),
        .infect_rate    (infect_rate),
        .recover_rate   (recover_rate),
        .start_infected (start_infected),
        .random_draw    (random_draw),
        .last_node      (last_node),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .node_out       (node_out),
        .next_infected  (next_infected),
        .sweep_done     (sweep_done),
        .any_infected   (any_infected),
        .list_full      (list_full)
    );

endmodule

/* rtl/sis_ram.sv */
module sis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sis_ctrl.sv */
module sis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  sis_pkg::stat_t    stat,
    output sis_pkg::ctrl_t    ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_LOOK,
        S_DEG,
        S_ADD,
        S_SCAN,
        S_MUL,
        S_CMP,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        sis_pkg::CMD_ADD_EDGE: state_next = S_LOOK;
                        sis_pkg::CMD_EVAL:     state_next = S_LOOK;
                        sis_pkg::CMD_SET_NODE: state_next = S_SET;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_SET:  state_next = S_IDLE;
            S_LOOK: state_next = S_DEG;
            S_DEG:
            begin
                if (stat.cmd == sis_pkg::CMD_ADD_EDGE)
                begin
                    state_next = S_ADD;
                end
                else if (stat.self_inf || stat.deg_zero)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_ADD:  state_next = S_FIN;
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_CMP;
            S_CMP:  state_next = S_FIN;
            S_FIN:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctrl           = '0;
        ctrl.item_ld   = in_valid && in_ready;
        ctrl.set_wr    = (state_reg == S_SET);
        ctrl.look      = (state_reg == S_LOOK);
        ctrl.deg_ld    = (state_reg == S_DEG);
        ctrl.add_wr    = (state_reg == S_ADD);
        ctrl.scan_step = (state_reg == S_SCAN);
        ctrl.mul_ld    = (state_reg == S_MUL);
        ctrl.cmp_ld    = (state_reg == S_CMP);
        ctrl.res_ld    = (state_reg == S_FIN) && stat.slot_free;
    end

endmodule

/* rtl/sis_dp.sv */
module sis_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sis_pkg::ctrl_t                ctrl,
    output sis_pkg::stat_t                stat,
    input  logic [1:0]                    cmd,
    input  logic [sis_pkg::NODE_W-1:0]    node,
    input  logic [sis_pkg::NODE_W-1:0]    neighbor,
    input  logic [sis_pkg::RATE_BITS-1:0] infect_rate,
    input  logic [sis_pkg::RATE_BITS-1:0] recover_rate,
    input  logic                          start_infected,
    input  logic [sis_pkg::DRAW_BITS-1:0] random_draw,
    input  logic                          last_node,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sis_pkg::NODE_W-1:0]    node_out,
    output logic                          next_infected,
    output logic                          sweep_done,
    output logic                          any_infected,
    output logic                          list_full
);

    localparam int NW = sis_pkg::NODE_W;
    localparam int DW = sis_pkg::DEG_W;
    localparam int SW = sis_pkg::SLOT_W;
    localparam int RW = sis_pkg::RATE_BITS;
    localparam int QW = sis_pkg::DRAW_BITS;

    // item
    logic [1:0]     cmd_reg;
    logic [NW-1:0]  node_reg;
    logic [NW-1:0]  nbr_reg;
    logic [RW-1:0]  irate_reg;
    logic [RW-1:0]  rrate_reg;
    logic           start_reg;
    logic [QW-1:0]  draw_reg;
    logic           last_reg;

    // work
    logic [DW-1:0]  deg_reg;
    logic           self_inf_reg;
    logic [RW-1:0]  irate_rd_reg;
    logic [RW-1:0]  rrate_rd_reg;
    logic [DW-1:0]  k_reg;
    logic [DW-1:0]  cnt_reg;
    logic [sis_pkg::PD_W-1:0] prod_d_reg;
    logic [sis_pkg::PR_W-1:0] prod_r_reg;

    // pending result
    logic           res_nxt_reg;
    logic           res_done_reg;
    logic           res_any_reg;
    logic           res_full_reg;

    // output beat
    logic           out_valid_reg;
    logic [NW-1:0]  node_out_reg;
    logic           next_infected_reg;
    logic           sweep_done_reg;
    logic           any_infected_reg;
    logic           list_full_reg;

    // node state
    logic [sis_pkg::MAX_NODES-1:0] deg_vld_reg;
    logic [sis_pkg::MAX_NODES-1:0] cur_reg;
    logic [sis_pkg::MAX_NODES-1:0] nxt_buf_reg;
    logic [sis_pkg::MAX_NODES-1:0] nxt_upd;

    logic [DW-1:0]   deg_q;
    logic [DW-1:0]   deg_cur;
    logic [2*RW-1:0] rate_q;
    logic [NW-1:0]   nbr_q;
    logic [DW-1:0]   k_plus;
    logic [SW-1:0]   rd_slot;
    logic            full;
    logic            add_we;
    logic            nxt_bit;
    logic            slot_free;

    assign deg_cur   = deg_vld_reg[node_reg] ? deg_q : '0;
    assign k_plus    = k_reg + DW'(1);
    assign rd_slot   = ctrl.deg_ld ? '0 : k_plus[SW-1:0];
    assign full      = (deg_reg >= DW'(sis_pkg::MAX_DEGREE));
    assign add_we    = ctrl.add_wr && !full;
    assign slot_free = !out_valid_reg || out_ready;

    sis_ram #(
        .WIDTH (NW),
        .DEPTH (sis_pkg::NBR_DEPTH)
    ) u_nbr_ram (
        .clk   (clk),
        .we    (add_we),
        .waddr ({node_reg, deg_reg[SW-1:0]}),
        .wdata (nbr_reg),
        .re    (ctrl.deg_ld || ctrl.scan_step),
        .raddr ({node_reg, rd_slot}),
        .rdata (nbr_q)
    );

    sis_ram #(
        .WIDTH (DW),
        .DEPTH (sis_pkg::MAX_NODES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (add_we),
        .waddr (node_reg),
        .wdata (deg_reg + DW'(1)),
        .re    (ctrl.look),
        .raddr (node_reg),
        .rdata (deg_q)
    );

    sis_ram #(
        .WIDTH (2 * RW),
        .DEPTH (sis_pkg::MAX_NODES)
    ) u_rate_ram (
        .clk   (clk),
        .we    (ctrl.set_wr),
        .waddr (node_reg),
        .wdata ({irate_reg, rrate_reg}),
        .re    (ctrl.look),
        .raddr (node_reg),
        .rdata (rate_q)
    );

    always_comb
    begin
        if (self_inf_reg)
        begin
            nxt_bit = !({draw_reg, {RW{1'b0}}} < {rrate_rd_reg, {QW{1'b0}}});
        end
        else
        begin
            nxt_bit = ({prod_d_reg, {RW{1'b0}}} < {prod_r_reg, {QW{1'b0}}});
        end
        nxt_upd           = nxt_buf_reg;
        nxt_upd[node_reg] = nxt_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            deg_vld_reg   <= '0;
            cur_reg       <= '0;
            nxt_buf_reg   <= '0;
        end
        else
        begin
            if (ctrl.res_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (add_we)
            begin
                deg_vld_reg[node_reg] <= 1'b1;
            end
            if (ctrl.set_wr)
            begin
                cur_reg[node_reg] <= start_reg;
            end
            if (ctrl.cmp_ld)
            begin
                nxt_buf_reg <= nxt_upd;
                if (last_reg)
                begin
                    cur_reg <= nxt_upd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.item_ld)
        begin
            cmd_reg   <= cmd;
            node_reg  <= node;
            nbr_reg   <= neighbor;
            irate_reg <= infect_rate;
            rrate_reg <= recover_rate;
            start_reg <= start_infected;
            draw_reg  <= random_draw;
            last_reg  <= last_node;
        end
        if (ctrl.deg_ld)
        begin
            deg_reg      <= deg_cur;
            self_inf_reg <= cur_reg[node_reg];
            irate_rd_reg <= rate_q[2*RW-1:RW];
            rrate_rd_reg <= rate_q[RW-1:0];
            k_reg        <= '0;
            cnt_reg      <= '0;
        end
        if (ctrl.scan_step)
        begin
            k_reg   <= k_plus;
            cnt_reg <= cnt_reg + DW'(cur_reg[nbr_q]);
        end
        if (ctrl.mul_ld)
        begin
            prod_d_reg <= sis_pkg::PD_W'(draw_reg) * sis_pkg::PD_W'(deg_reg);
            prod_r_reg <= sis_pkg::PR_W'(irate_rd_reg) * sis_pkg::PR_W'(cnt_reg);
        end
        if (ctrl.add_wr)
        begin
            res_nxt_reg  <= 1'b0;
            res_done_reg <= 1'b0;
            res_any_reg  <= 1'b0;
            res_full_reg <= full;
        end
        if (ctrl.cmp_ld)
        begin
            res_nxt_reg  <= nxt_bit;
            res_done_reg <= last_reg;
            res_any_reg  <= last_reg && (|nxt_upd);
            res_full_reg <= 1'b0;
        end
        if (ctrl.res_ld)
        begin
            node_out_reg      <= node_reg;
            next_infected_reg <= res_nxt_reg;
            sweep_done_reg    <= res_done_reg;
            any_infected_reg  <= res_any_reg;
            list_full_reg     <= res_full_reg;
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.self_inf  = cur_reg[node_reg];
    assign stat.deg_zero  = (deg_cur == '0);
    assign stat.scan_last = (k_plus == deg_reg);
    assign stat.slot_free = slot_free;

    assign out_valid     = out_valid_reg;
    assign node_out      = node_out_reg;
    assign next_infected = next_infected_reg;
    assign sweep_done    = sweep_done_reg;
    assign any_infected  = any_infected_reg;
    assign list_full     = list_full_reg;

    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.res_ld |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an unaccepted beat");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && list_full_reg) |-> (!sweep_done_reg && !next_infected_reg))
        else $error("dropped edge beat carries evaluate flags");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmp_ld && last_reg) |=> (cur_reg == nxt_buf_reg))
        else $error("commit did not copy the next buffer");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.scan_step |-> (k_reg < deg_reg))
        else $error("neighbor scan past degree");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 640;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic [sis_pkg::NODE_W-1:0]    node;
        logic [sis_pkg::NODE_W-1:0]    nbr;
        logic [sis_pkg::RATE_BITS-1:0] irate;
        logic [sis_pkg::RATE_BITS-1:0] rrate;
        logic                          start;
        logic [sis_pkg::DRAW_BITS-1:0] draw;
        logic                          last;
    } stim_t;

    typedef struct packed {
        logic [sis_pkg::NODE_W-1:0] node;
        logic                       inf;
        logic                       done;
        logic                       any;
        logic                       full;
    } outcome_t;

    typedef struct packed {
        stim_t    s;
        logic [4:0] reps;
        logic     typed;
        outcome_t res;
    } row_t;

    localparam int N_ROWS = 19;

    row_t directed_rows [N_ROWS] = '{
        '{'{sis_pkg::CMD_ADD_EDGE, 6'd0, 6'd63, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_SET_NODE, 6'd0, 6'd0, 16'hFFFF, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_SET_NODE, 6'd63, 6'd0, 16'h0, 16'hFFFF, 1'b1, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd0, 6'd0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_EVAL, 6'd63, 6'd0, 16'h0, 16'h0, 1'b0, 16'hFFFF, 1'b0},
          5'd1, 1'b1, '{6'd63, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_EVAL, 6'd63, 6'd0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b1, '{6'd63, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_SET_NODE, 6'd5, 6'd0, 16'hFFFF, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd5, 6'd0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b1},
          5'd1, 1'b1, '{6'd5, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{sis_pkg::CMD_ADD_EDGE, 6'd1, 6'd2, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd16, 1'b1, '{6'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_ADD_EDGE, 6'd1, 6'd3, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b1, '{6'd1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{sis_pkg::CMD_SET_NODE, 6'd1, 6'd0, 16'h8000, 16'h1234, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_SET_NODE, 6'd2, 6'd0, 16'h0, 16'h0, 1'b1, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd1, 6'd0, 16'h0, 16'h0, 1'b0, 16'hFFFF, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd1, 6'd0, 16'h0, 16'h0, 1'b0, 16'h7FFF, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_SET_NODE, 6'd0, 6'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd0, 6'd0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
          5'd1, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{sis_pkg::CMD_EVAL, 6'd1, 6'd0, 16'h0, 16'h0, 1'b0, 16'hFFFF, 1'b0},
          5'd1, 1'b0, '0},
        '{'{sis_pkg::CMD_EVAL, 6'd5, 6'd0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b1},
          5'd1, 1'b1, '{6'd5, 1'b0, 1'b1, 1'b0, 1'b0}}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [1:0]                    cmd = '0;
    logic [sis_pkg::NODE_W-1:0]    node = '0;
    logic [sis_pkg::NODE_W-1:0]    neighbor = '0;
    logic [sis_pkg::RATE_BITS-1:0] infect_rate = '0;
    logic [sis_pkg::RATE_BITS-1:0] recover_rate = '0;
    logic                          start_infected = 1'b0;
    logic [sis_pkg::DRAW_BITS-1:0] random_draw = '0;
    logic                          last_node = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [sis_pkg::NODE_W-1:0]    node_out;
    logic                          next_infected;
    logic                          sweep_done;
    logic                          any_infected;
    logic                          list_full;

    // graph and epidemic state as the block should hold it
    logic [sis_pkg::NODE_W-1:0]    nbr_list [sis_pkg::MAX_NODES][sis_pkg::MAX_DEGREE];
    logic [sis_pkg::DEG_W-1:0]     node_degree [sis_pkg::MAX_NODES] = '{default: '0};
    logic [sis_pkg::RATE_BITS-1:0] node_irate [sis_pkg::MAX_NODES];
    logic [sis_pkg::RATE_BITS-1:0] node_rrate [sis_pkg::MAX_NODES];
    bit [sis_pkg::MAX_NODES-1:0]   infected_now = '0;
    bit [sis_pkg::MAX_NODES-1:0]   infected_next = '0;
    bit [sis_pkg::MAX_NODES-1:0]   rates_loaded = '0;

    outcome_t expected_results [$];
    int       error_count = 0;
    bit       quiet = 1'b0;

    sis_contact_process_step_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .node           (node),
        .neighbor       (neighbor),
        .infect_rate    (infect_rate),
        .recover_rate   (recover_rate),
        .start_infected (start_infected),
        .random_draw    (random_draw),
        .last_node      (last_node),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .node_out       (node_out),
        .next_infected  (next_infected),
        .sweep_done     (sweep_done),
        .any_infected   (any_infected),
        .list_full      (list_full)
    );

    always #5 clk = ~clk;

    function automatic bit step_epidemic(input stim_t s, output outcome_t r);
        int unsigned      hits;
        longint unsigned  lhs;
        longint unsigned  rhs;
        r = '0;
        r.node = s.node;
        if (s.cmd == sis_pkg::CMD_ADD_EDGE)
        begin
            if (node_degree[s.node] >= sis_pkg::MAX_DEGREE)
                r.full = 1'b1;
            else
            begin
                nbr_list[s.node][node_degree[s.node]] = s.nbr;
                node_degree[s.node] = node_degree[s.node] + sis_pkg::DEG_W'(1);
            end
            return 1'b1;
        end
        if (s.cmd == sis_pkg::CMD_SET_NODE)
        begin
            node_irate[s.node] = s.irate;
            node_rrate[s.node] = s.rrate;
            infected_now[s.node] = s.start;
            rates_loaded[s.node] = 1'b1;
            return 1'b0;
        end
        if (s.cmd != sis_pkg::CMD_EVAL)
            return 1'b0;
        if (!infected_now[s.node])
        begin
            hits = 0;
            for (int k = 0; k < node_degree[s.node]; k++)
                hits += infected_now[nbr_list[s.node][k]];
            lhs = 64'(s.draw);
            lhs = (lhs * 64'(node_degree[s.node])) << sis_pkg::RATE_BITS;
            rhs = 64'(node_irate[s.node]);
            rhs = (rhs * 64'(hits)) << sis_pkg::DRAW_BITS;
            r.inf = (lhs < rhs);
        end
        else
        begin
            lhs = 64'(s.draw);
            lhs = lhs << sis_pkg::RATE_BITS;
            rhs = 64'(node_rrate[s.node]);
            rhs = rhs << sis_pkg::DRAW_BITS;
            r.inf = !(lhs < rhs);
        end
        infected_next[s.node] = r.inf;
        if (s.last)
        begin
            infected_now = infected_next;
            r.done = 1'b1;
            r.any = |infected_now;
        end
        return 1'b1;
    endfunction

    task automatic run_item(input stim_t s, input bit typed, input outcome_t typed_res);
        int       gap;
        outcome_t r;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= s.cmd;
        node           <= s.node;
        neighbor       <= s.nbr;
        infect_rate    <= s.irate;
        recover_rate   <= s.rrate;
        start_infected <= s.start;
        random_draw    <= s.draw;
        last_node      <= s.last;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        if (step_epidemic(s, r))
            expected_results.push_back(typed ? typed_res : r);
    endtask

    initial
    begin
        stim_t s;
        int    n_items;
        int    pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            for (int r = 0; r < directed_rows[i].reps; r++)
                run_item(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].res);

        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            if (n_items % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            s.node  = sis_pkg::NODE_W'($urandom);
            s.nbr   = sis_pkg::NODE_W'($urandom);
            s.irate = sis_pkg::RATE_BITS'($urandom);
            s.rrate = sis_pkg::RATE_BITS'($urandom);
            s.start = 1'($urandom);
            s.draw  = sis_pkg::DRAW_BITS'($urandom);
            s.last  = 1'($urandom);
            if (pick < 4)
                s.cmd = CMD_UNUSED;
            else if (pick < 20 || rates_loaded == '0)
            begin
                s.cmd = sis_pkg::CMD_SET_NODE;
                case ($urandom_range(0, 5))
                    0: s.irate = '0;
                    1: s.irate = '1;
                    2: s.rrate = '0;
                    3: s.rrate = '1;
                    default: ;
                endcase
            end
            else if (pick < 42)
            begin
                s.cmd = sis_pkg::CMD_ADD_EDGE;
                if ($urandom_range(0, 1))
                    s.node = sis_pkg::NODE_W'($urandom_range(0, 3));
            end
            else
            begin
                s.cmd = sis_pkg::CMD_EVAL;
                do
                    s.node = sis_pkg::NODE_W'($urandom);
                while (!rates_loaded[s.node]);
                s.last = ($urandom_range(0, 9) == 0);
            end
            run_item(s, 1'b0, '0);
            if (s.cmd != CMD_UNUSED)
                n_items++;
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("** sis_contact_process_step_core: PASSED **");
        else
            $display("** sis_contact_process_step_core: FAILED **");
        $finish;
    end

    // result side: random stall before each beat, none while quiet
    initial
    begin
        int       stall;
        outcome_t e;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("unexpected beat for node %0d", node_out);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (node_out !== e.node)
                begin
                    $error("node_out: expected %0d, got %0d", e.node, node_out);
                    error_count++;
                end
                if (next_infected !== e.inf)
                begin
                    $error("next_infected: expected %0b, got %0b", e.inf, next_infected);
                    error_count++;
                end
                if (sweep_done !== e.done)
                begin
                    $error("sweep_done: expected %0b, got %0b", e.done, sweep_done);
                    error_count++;
                end
                if (any_infected !== e.any)
                begin
                    $error("any_infected: expected %0b, got %0b", e.any, any_infected);
                    error_count++;
                end
                if (list_full !== e.full)
                begin
                    $error("list_full: expected %0b, got %0b", e.full, list_full);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** sis_contact_process_step_core: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sis_pkg.sv
rtl/sis_ram.sv
rtl/sis_ctrl.sv
rtl/sis_dp.sv
rtl/sis_contact_process_step_core.sv
tb/testbench.sv
